FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the wedge shape-function block.
// Depends on nothing; the macros are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
	else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/w15_pkg.sv
// Package for the 15-node wedge shape-function evaluator.
// Holds node count, scale codes and shared types; depends on nothing.
`timescale 1ns / 1ps
package w15_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int NODE_COUNT = 15;
	localparam int COORD_X_W = 18;
	localparam int COORD_YZ_W = 17;
	localparam int VALUE_W = 21;
	localparam int LANES = 4;

	typedef logic [3:0] node_idx_t;
	typedef logic [1:0] kcode_t;

	localparam node_idx_t LAST_NODE = node_idx_t'(NODE_COUNT - 1);

	// Scale applied to a term: one half, one or two.
	localparam kcode_t K_HALF = 2'd0;
	localparam kcode_t K_ONE  = 2'd1;
	localparam kcode_t K_TWO  = 2'd2;
endpackage

FILE: sv/wedge15_shape_function_eval.sv
// Top level of the 15-node wedge shape-function evaluator.
// Uses w15_pkg and assert_macros.svh.
//
// Channel  Direction  Handshake            Payload
// in       receive    in_valid/in_stall    coord_x, coord_y, coord_z
// out      send       out_valid/out_stall  node_index, shape_value, deriv_x/y/z, last_node
//
// Each accepted point yields fifteen results, one per cycle unless the output stalls;
// the node sequencer, which issues one node per cycle unless the output stalls, sets that pace.
// The first result passes from the sequencer through stage registers s1 to s5 to the output.
// A new point is taken in the cycle that the last node of the previous one is issued.
// A stall with out_valid high freezes the whole five-stage pipeline; nothing is lost.
// Reset clears the sequencer and all valid bits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wedge15_shape_function_eval #(
	parameter int FRAC_BITS = w15_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [w15_pkg::COORD_X_W-1:0] coord_x,
	input  logic [w15_pkg::COORD_YZ_W-1:0] coord_y,
	input  logic [w15_pkg::COORD_YZ_W-1:0] coord_z,
	output logic out_valid,
	input  logic out_stall,
	output w15_pkg::node_idx_t node_index,
	output logic signed [w15_pkg::VALUE_W-1:0] shape_value,
	output logic signed [w15_pkg::VALUE_W-1:0] deriv_x,
	output logic signed [w15_pkg::VALUE_W-1:0] deriv_y,
	output logic signed [w15_pkg::VALUE_W-1:0] deriv_z,
	output logic last_node
);
	import w15_pkg::*;

	localparam int FW = ((FRAC_BITS > COORD_YZ_W) ? FRAC_BITS : COORD_YZ_W) + 6;
	localparam int PW = 3 * FW;
	localparam logic signed [FW-1:0] ONE = {{(FW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic signed [PW-1:0] P_UNIT = {{(PW-1){1'b0}}, 1'b1};
	localparam logic signed [PW-1:0] BIAS_H = P_UNIT << (2 * FRAC_BITS);
	localparam logic signed [PW-1:0] BIAS_U = P_UNIT << (2 * FRAC_BITS - 1);
	localparam logic signed [PW-1:0] BIAS_T = P_UNIT << (2 * FRAC_BITS - 2);
	localparam logic signed [PW-1:0] LIM = P_UNIT << (FRAC_BITS + 3);

	logic adv, issue, in_acc;

	// Sequencer: the current point and the node to issue next.
	logic busy_q;
	node_idx_t node_q;
	logic signed [FW-1:0] x_q, y_q, z_q, l_q, xm_q, xp_q;
	logic signed [FW-1:0] xi, yi, zi;

	assign adv = !out_valid || !out_stall;
	assign issue = busy_q && adv;
	assign in_stall = busy_q && !(issue && node_q == LAST_NODE);
	assign in_acc = in_valid && !in_stall;

	assign xi = {{(FW-COORD_X_W){coord_x[COORD_X_W-1]}}, coord_x};
	assign yi = {{(FW-COORD_YZ_W){1'b0}}, coord_y};
	assign zi = {{(FW-COORD_YZ_W){1'b0}}, coord_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			node_q <= '0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
			node_q <= '0;
		end else if (issue && node_q == LAST_NODE) begin
			busy_q <= 1'b0;
			node_q <= '0;
		end else if (issue) begin
			node_q <= node_q + node_idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= xi;
			y_q <= yi;
			z_q <= zi;
			l_q <= ONE - yi - zi;
			xm_q <= ONE - xi;
			xp_q <= ONE + xi;
		end
	end

	// Factor selection: each lane is k * a * b * c.
	logic signed [FW-1:0] fa [LANES];
	logic signed [FW-1:0] fb [LANES];
	logic signed [FW-1:0] fc [LANES];
	kcode_t fk [LANES];

	always_comb begin
		logic signed [FW-1:0] x, y, z, l, xm, xp;
		x = x_q;
		y = y_q;
		z = z_q;
		l = l_q;
		xm = xm_q;
		xp = xp_q;
		for (int i = 0; i < LANES; i++) begin
			fa[i] = '0;
			fb[i] = '0;
			fc[i] = '0;
			fk[i] = K_ONE;
		end
		case (node_q)
			4'd0: begin
				fa[0] = y; fb[0] = xm; fc[0] = (y <<< 1) - (ONE <<< 1) - x; fk[0] = K_HALF;
				fa[1] = y; fb[1] = (x <<< 1) - (y <<< 1) + ONE; fc[1] = ONE; fk[1] = K_HALF;
				fa[2] = xm; fb[2] = (y <<< 2) - x - (ONE <<< 1); fc[2] = ONE; fk[2] = K_HALF;
			end
			4'd1: begin
				fa[0] = z; fb[0] = xm; fc[0] = (z <<< 1) - (ONE <<< 1) - x; fk[0] = K_HALF;
				fa[1] = z; fb[1] = (x <<< 1) - (z <<< 1) + ONE; fc[1] = ONE; fk[1] = K_HALF;
				fa[3] = xm; fb[3] = (z <<< 2) - x - (ONE <<< 1); fc[3] = ONE; fk[3] = K_HALF;
			end
			4'd2: begin
				fa[0] = -xm; fb[0] = l; fc[0] = x + (y <<< 1) + (z <<< 1); fk[0] = K_HALF;
				fa[1] = (x <<< 1) + (y <<< 1) + (z <<< 1) - ONE; fb[1] = l; fc[1] = ONE;
				fk[1] = K_HALF;
				fa[2] = xm; fb[2] = (y <<< 2) + (z <<< 2) + x - (ONE <<< 1); fc[2] = ONE;
				fk[2] = K_HALF;
				fa[3] = fa[2]; fb[3] = fb[2]; fc[3] = ONE; fk[3] = K_HALF;
			end
			4'd3: begin
				fa[0] = y; fb[0] = xp; fc[0] = (y <<< 1) - (ONE <<< 1) + x; fk[0] = K_HALF;
				fa[1] = y; fb[1] = (x <<< 1) + (y <<< 1) - ONE; fc[1] = ONE; fk[1] = K_HALF;
				fa[2] = xp; fb[2] = (y <<< 2) + x - (ONE <<< 1); fc[2] = ONE; fk[2] = K_HALF;
			end
			4'd4: begin
				fa[0] = z; fb[0] = xp; fc[0] = (z <<< 1) - (ONE <<< 1) + x; fk[0] = K_HALF;
				fa[1] = z; fb[1] = (x <<< 1) + (z <<< 1) - ONE; fc[1] = ONE; fk[1] = K_HALF;
				fa[3] = xp; fb[3] = (z <<< 2) + x - (ONE <<< 1); fc[3] = ONE; fk[3] = K_HALF;
			end
			4'd5: begin
				fa[0] = -xp; fb[0] = l; fc[0] = (y <<< 1) + (z <<< 1) - x; fk[0] = K_HALF;
				fa[1] = l; fb[1] = (x <<< 1) - (y <<< 1) - (z <<< 1) + ONE; fc[1] = ONE;
				fk[1] = K_HALF;
				fa[2] = xp; fb[2] = (y <<< 2) + (z <<< 2) - x - (ONE <<< 1); fc[2] = ONE;
				fk[2] = K_HALF;
				fa[3] = fa[2]; fb[3] = fb[2]; fc[3] = ONE; fk[3] = K_HALF;
			end
			4'd6: begin
				fa[0] = y; fb[0] = z; fc[0] = xm; fk[0] = K_TWO;
				fa[1] = -y; fb[1] = z; fc[1] = ONE; fk[1] = K_TWO;
				fa[2] = xm; fb[2] = z; fc[2] = ONE; fk[2] = K_TWO;
				fa[3] = xm; fb[3] = y; fc[3] = ONE; fk[3] = K_TWO;
			end
			4'd7: begin
				fa[0] = z; fb[0] = l; fc[0] = xm; fk[0] = K_TWO;
				fa[1] = z; fb[1] = -l; fc[1] = ONE; fk[1] = K_TWO;
				fa[2] = z; fb[2] = -xm; fc[2] = ONE; fk[2] = K_TWO;
				fa[3] = -xm; fb[3] = (z <<< 1) + y - ONE; fc[3] = ONE; fk[3] = K_TWO;
			end
			4'd8: begin
				fa[0] = y; fb[0] = xm; fc[0] = l; fk[0] = K_TWO;
				fa[1] = y; fb[1] = -l; fc[1] = ONE; fk[1] = K_TWO;
				fa[2] = (y <<< 1) + z - ONE; fb[2] = -xm; fc[2] = ONE; fk[2] = K_TWO;
				fa[3] = y; fb[3] = -xm; fc[3] = ONE; fk[3] = K_TWO;
			end
			4'd9: begin
				fa[0] = y; fb[0] = xm; fc[0] = xp; fk[0] = K_ONE;
				fa[1] = -x; fb[1] = y; fc[1] = ONE; fk[1] = K_TWO;
				fa[2] = xm; fb[2] = xp; fc[2] = ONE; fk[2] = K_ONE;
			end
			4'd10: begin
				fa[0] = z; fb[0] = xm; fc[0] = xp; fk[0] = K_ONE;
				fa[1] = -x; fb[1] = z; fc[1] = ONE; fk[1] = K_TWO;
				fa[3] = xm; fb[3] = xp; fc[3] = ONE; fk[3] = K_ONE;
			end
			4'd11: begin
				fa[0] = l; fb[0] = xm; fc[0] = xp; fk[0] = K_ONE;
				fa[1] = x; fb[1] = -l; fc[1] = ONE; fk[1] = K_TWO;
				fa[2] = -xm; fb[2] = xp; fc[2] = ONE; fk[2] = K_ONE;
				fa[3] = -xm; fb[3] = xp; fc[3] = ONE; fk[3] = K_ONE;
			end
			4'd12: begin
				fa[0] = y; fb[0] = z; fc[0] = xp; fk[0] = K_TWO;
				fa[1] = y; fb[1] = z; fc[1] = ONE; fk[1] = K_TWO;
				fa[2] = z; fb[2] = xp; fc[2] = ONE; fk[2] = K_TWO;
				fa[3] = xp; fb[3] = y; fc[3] = ONE; fk[3] = K_TWO;
			end
			4'd13: begin
				fa[0] = z; fb[0] = l; fc[0] = xp; fk[0] = K_TWO;
				fa[1] = z; fb[1] = l; fc[1] = ONE; fk[1] = K_TWO;
				fa[2] = -z; fb[2] = xp; fc[2] = ONE; fk[2] = K_TWO;
				fa[3] = xp; fb[3] = ONE - (z <<< 1) - y; fc[3] = ONE; fk[3] = K_TWO;
			end
			4'd14: begin
				fa[0] = y; fb[0] = l; fc[0] = xp; fk[0] = K_TWO;
				fa[1] = y; fb[1] = l; fc[1] = ONE; fk[1] = K_TWO;
				fa[2] = ONE - (y <<< 1) - z; fb[2] = xp; fc[2] = ONE; fk[2] = K_TWO;
				fa[3] = xp; fb[3] = -y; fc[3] = ONE; fk[3] = K_TWO;
			end
			default: begin
			end
		endcase
	end

	// Pipeline registers.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	node_idx_t node_s1, node_s2, node_s3, node_s4, node_s5;
	logic signed [FW-1:0] a_s1 [LANES];
	logic signed [FW-1:0] b_s1 [LANES];
	logic signed [FW-1:0] c_s1 [LANES];
	logic signed [FW-1:0] c_s2 [LANES];
	logic signed [2*FW-1:0] ab_s2 [LANES];
	logic signed [2*FW:0] plo_s3 [LANES];
	logic signed [2*FW-1:0] phi_s3 [LANES];
	logic signed [PW-1:0] p_s4 [LANES];
	logic signed [VALUE_W-1:0] r_s5 [LANES];
	kcode_t k_s1 [LANES];
	kcode_t k_s2 [LANES];
	kcode_t k_s3 [LANES];
	kcode_t k_s4 [LANES];
	logic signed [PW-1:0] rnd [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Round to nearest with ties upward, then clamp to plus or minus eight.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			case (k_s4[i])
				K_HALF: rnd[i] = (p_s4[i] + BIAS_H) >>> (2 * FRAC_BITS + 1);
				K_TWO: rnd[i] = (p_s4[i] + BIAS_T) >>> (2 * FRAC_BITS - 1);
				default: rnd[i] = (p_s4[i] + BIAS_U) >>> (2 * FRAC_BITS);
			endcase
			if (rnd[i] > LIM)
				rnd[i] = LIM;
			else if (rnd[i] < -LIM)
				rnd[i] = -LIM;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			node_s1 <= node_q;
			node_s2 <= node_s1;
			node_s3 <= node_s2;
			node_s4 <= node_s3;
			node_s5 <= node_s4;
			for (int i = 0; i < LANES; i++) begin
				a_s1[i] <= fa[i];
				b_s1[i] <= fb[i];
				c_s1[i] <= fc[i];
				k_s1[i] <= fk[i];
				ab_s2[i] <= a_s1[i] * b_s1[i];
				c_s2[i] <= c_s1[i];
				k_s2[i] <= k_s1[i];
				// The triple product is built from two partial products of the pair product.
				plo_s3[i] <= $signed({1'b0, ab_s2[i][FW-1:0]}) * c_s2[i];
				phi_s3[i] <= $signed(ab_s2[i][2*FW-1:FW]) * c_s2[i];
				k_s3[i] <= k_s2[i];
				p_s4[i] <= ({{FW{phi_s3[i][2*FW-1]}}, phi_s3[i]} << FW)
					+ {{(PW-2*FW-1){plo_s3[i][2*FW]}}, plo_s3[i]};
				k_s4[i] <= k_s3[i];
				r_s5[i] <= rnd[i][VALUE_W-1:0];
			end
		end
	end

	assign out_valid = v_s5;
	assign node_index = node_s5;
	assign shape_value = r_s5[0];
	assign deriv_x = r_s5[1];
	assign deriv_y = r_s5[2];
	assign deriv_z = r_s5[3];
	assign last_node = (node_s5 == LAST_NODE);

	`ASSERT_IMPL(a_acc_on_last, clk, arst_n, in_acc && busy_q, node_q == LAST_NODE)
	`ASSERT_IMPL(a_node_range, clk, arst_n, busy_q, node_q <= LAST_NODE)
	`ASSERT_IMPL(a_idle_node, clk, arst_n, !busy_q, node_q == '0)
endmodule

FILE: dv/w15_checker.sv
// Checker for the 15-node wedge shape-function evaluator: watches both channels,
// predicts the fifteen node results of each accepted point and compares them.
// Depends on w15_pkg.
`timescale 1ns / 1ps
module w15_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic signed [w15_pkg::COORD_X_W-1:0] coord_x,
	input  logic [w15_pkg::COORD_YZ_W-1:0] coord_y,
	input  logic [w15_pkg::COORD_YZ_W-1:0] coord_z,
	input  logic out_valid,
	input  logic out_stall,
	input  w15_pkg::node_idx_t node_index,
	input  logic signed [w15_pkg::VALUE_W-1:0] shape_value,
	input  logic signed [w15_pkg::VALUE_W-1:0] deriv_x,
	input  logic signed [w15_pkg::VALUE_W-1:0] deriv_y,
	input  logic signed [w15_pkg::VALUE_W-1:0] deriv_z,
	input  logic last_node,
	output int fail_count,
	output int pending
);
	import w15_pkg::*;

	localparam int FB = FRAC_BITS_DEF;

	typedef struct packed {
		node_idx_t node;
		logic signed [VALUE_W-1:0] val;
		logic signed [VALUE_W-1:0] dx;
		logic signed [VALUE_W-1:0] dy;
		logic signed [VALUE_W-1:0] dz;
		logic last;
	} node_result_t;

	node_result_t node_results_q[$];

	// Exact product of three factors scaled by the k code, rounded to nearest with
	// ties upward, then saturated to plus or minus 8.0.
	function automatic logic signed [VALUE_W-1:0] scaled_product(longint a, longint b,
			longint c, kcode_t k);
		logic signed [127:0] p;
		logic signed [127:0] r;
		int sh;
		sh = (k == K_HALF) ? 2*FB + 1 : (k == K_TWO) ? 2*FB - 1 : 2*FB;
		p = 128'(a) * 128'(b) * 128'(c);
		r = (p + (128'sd1 <<< (sh - 1))) >>> sh;
		if (r > (128'sd8 <<< FB))
			r = 128'sd8 <<< FB;
		else if (r < -(128'sd8 <<< FB))
			r = -(128'sd8 <<< FB);
		return r[VALUE_W-1:0];
	endfunction

	task automatic predict_nodes(longint x, longint y, longint z);
		longint one, l, xm, xp;
		logic signed [VALUE_W-1:0] v[NODE_COUNT][4];
		node_result_t res;
		one = longint'(1) << FB;
		l = one - y - z;
		xm = one - x;
		xp = one + x;
		v[0][0] = scaled_product(y, xm, 2*y - 2*one - x, K_HALF);
		v[0][1] = scaled_product(y, 2*x - 2*y + one, one, K_HALF);
		v[0][2] = scaled_product(xm, 4*y - x - 2*one, one, K_HALF);
		v[0][3] = '0;
		v[1][0] = scaled_product(z, xm, 2*z - 2*one - x, K_HALF);
		v[1][1] = scaled_product(z, 2*x - 2*z + one, one, K_HALF);
		v[1][2] = '0;
		v[1][3] = scaled_product(xm, 4*z - x - 2*one, one, K_HALF);
		v[2][0] = scaled_product(-xm, l, x + 2*y + 2*z, K_HALF);
		v[2][1] = scaled_product(2*x + 2*y + 2*z - one, l, one, K_HALF);
		v[2][2] = scaled_product(xm, 4*y + 4*z + x - 2*one, one, K_HALF);
		v[2][3] = v[2][2];
		v[3][0] = scaled_product(y, xp, 2*y - 2*one + x, K_HALF);
		v[3][1] = scaled_product(y, 2*x + 2*y - one, one, K_HALF);
		v[3][2] = scaled_product(xp, 4*y + x - 2*one, one, K_HALF);
		v[3][3] = '0;
		v[4][0] = scaled_product(z, xp, 2*z - 2*one + x, K_HALF);
		v[4][1] = scaled_product(z, 2*x + 2*z - one, one, K_HALF);
		v[4][2] = '0;
		v[4][3] = scaled_product(xp, 4*z + x - 2*one, one, K_HALF);
		v[5][0] = scaled_product(-xp, l, 2*y + 2*z - x, K_HALF);
		v[5][1] = scaled_product(l, 2*x - 2*y - 2*z + one, one, K_HALF);
		v[5][2] = scaled_product(xp, 4*y + 4*z - x - 2*one, one, K_HALF);
		v[5][3] = v[5][2];
		v[6][0] = scaled_product(y, z, xm, K_TWO);
		v[6][1] = scaled_product(-y, z, one, K_TWO);
		v[6][2] = scaled_product(xm, z, one, K_TWO);
		v[6][3] = scaled_product(xm, y, one, K_TWO);
		v[7][0] = scaled_product(z, l, xm, K_TWO);
		v[7][1] = scaled_product(z, -l, one, K_TWO);
		v[7][2] = scaled_product(z, -xm, one, K_TWO);
		v[7][3] = scaled_product(-xm, 2*z + y - one, one, K_TWO);
		v[8][0] = scaled_product(y, xm, l, K_TWO);
		v[8][1] = scaled_product(y, -l, one, K_TWO);
		v[8][2] = scaled_product(2*y + z - one, -xm, one, K_TWO);
		v[8][3] = scaled_product(y, -xm, one, K_TWO);
		v[9][0] = scaled_product(y, xm, xp, K_ONE);
		v[9][1] = scaled_product(-x, y, one, K_TWO);
		v[9][2] = scaled_product(xm, xp, one, K_ONE);
		v[9][3] = '0;
		v[10][0] = scaled_product(z, xm, xp, K_ONE);
		v[10][1] = scaled_product(-x, z, one, K_TWO);
		v[10][2] = '0;
		v[10][3] = scaled_product(xm, xp, one, K_ONE);
		v[11][0] = scaled_product(l, xm, xp, K_ONE);
		v[11][1] = scaled_product(x, -l, one, K_TWO);
		v[11][2] = scaled_product(-xm, xp, one, K_ONE);
		v[11][3] = v[11][2];
		v[12][0] = scaled_product(y, z, xp, K_TWO);
		v[12][1] = scaled_product(y, z, one, K_TWO);
		v[12][2] = scaled_product(z, xp, one, K_TWO);
		v[12][3] = scaled_product(xp, y, one, K_TWO);
		v[13][0] = scaled_product(z, l, xp, K_TWO);
		v[13][1] = scaled_product(z, l, one, K_TWO);
		v[13][2] = scaled_product(-z, xp, one, K_TWO);
		v[13][3] = scaled_product(xp, one - 2*z - y, one, K_TWO);
		v[14][0] = scaled_product(y, l, xp, K_TWO);
		v[14][1] = scaled_product(y, l, one, K_TWO);
		v[14][2] = scaled_product(one - 2*y - z, xp, one, K_TWO);
		v[14][3] = scaled_product(xp, -y, one, K_TWO);
		for (int n = 0; n < NODE_COUNT; n++) begin
			res.node = node_idx_t'(n);
			res.val = v[n][0];
			res.dx = v[n][1];
			res.dy = v[n][2];
			res.dz = v[n][3];
			res.last = (res.node == LAST_NODE);
			node_results_q.push_back(res);
		end
	endtask

	task automatic compare_field(string name, longint expv, longint act);
		if (expv != act) begin
			$error("%s mismatch: expected %0d, got %0d", name, expv, act);
			fail_count++;
		end
	endtask

	assign pending = node_results_q.size();

	// The failure count starts from the default value of an int, zero.
	always @(posedge clk) begin
		node_result_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (node_results_q.size() == 0) begin
					$error("unexpected result transaction for node %0d", node_index);
					fail_count++;
				end else begin
					e = node_results_q.pop_front();
					compare_field("node_index", e.node, node_index);
					compare_field("shape_value", e.val, shape_value);
					compare_field("deriv_x", e.dx, deriv_x);
					compare_field("deriv_y", e.dy, deriv_y);
					compare_field("deriv_z", e.dz, deriv_z);
					compare_field("last_node", e.last, last_node);
				end
			end
			if (in_valid && !in_stall)
				predict_nodes(longint'(coord_x), longint'(coord_y), longint'(coord_z));
		end
	end
endmodule

FILE: dv/tb_top.sv
// Testbench top for the 15-node wedge shape-function evaluator: drives coordinate
// points with random idling and gives the verdict. Depends on w15_pkg and w15_checker.
`timescale 1ns / 1ps
module tb_top;
	import w15_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_POINTS = 405;
	localparam int ONE = 1 << FRAC_BITS_DEF;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [COORD_X_W-1:0] coord_x;
	logic [COORD_YZ_W-1:0] coord_y;
	logic [COORD_YZ_W-1:0] coord_z;
	logic out_valid;
	logic out_stall;
	node_idx_t node_index;
	logic signed [VALUE_W-1:0] shape_value;
	logic signed [VALUE_W-1:0] deriv_x;
	logic signed [VALUE_W-1:0] deriv_y;
	logic signed [VALUE_W-1:0] deriv_z;
	logic last_node;
	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;

	wedge15_shape_function_eval u_top (.*);

	w15_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The receiver stalls at random; the percentage changes with the phase.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// Watchdog on cycles in which no transaction happens on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Valid stays high after the transaction so that points can follow back to back;
	// the caller drops it before waiting.
	task automatic send_point(int x, int y, int z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		coord_x <= COORD_X_W'(x);
		coord_y <= COORD_YZ_W'(y);
		coord_z <= COORD_YZ_W'(z);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Mostly points inside the element, with some raw bit patterns outside it.
	task automatic send_random_point();
		int y;
		if ($urandom_range(9) < 8) begin
			y = $urandom_range(ONE);
			send_point($urandom_range(2*ONE) - ONE, y, $urandom_range(ONE - y));
		end else begin
			send_point($urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		in_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Corners, mid-edge nodes, the centre and the extreme bit patterns.
		send_point(-ONE, 0, 0);
		send_point(-ONE, ONE, 0);
		send_point(-ONE, 0, ONE);
		send_point(ONE, 0, 0);
		send_point(ONE, ONE, 0);
		send_point(ONE, 0, ONE);
		send_point(-ONE, ONE/2, ONE/2);
		send_point(ONE, ONE/2, 0);
		send_point(0, 0, ONE/2);
		send_point(0, ONE, 0);
		send_point(0, ONE/3, ONE/3);
		send_point(1, 1, 1);
		send_point(-1, ONE - 1, 1);
		send_point((1 << 17) - 1, 0, 0);
		send_point(-(1 << 17), 0, 0);
		send_point((1 << 17) - 1, (1 << 17) - 1, (1 << 17) - 1);
		send_point(-(1 << 17), (1 << 17) - 1, (1 << 17) - 1);
		send_point(ONE, ONE, ONE);
		send_point(-ONE, ONE, ONE);
		send_point(12345, 33333, 21111);

		// The sender holds back until the block has drained.
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);

		for (int i = 0; i < RANDOM_POINTS; i++) begin
			if (i == RANDOM_POINTS / 3) begin
				send_idle_pct = 71;
				recv_idle_pct = 10;
			end else if (i == 2 * RANDOM_POINTS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (i == 0) begin
				send_idle_pct = 10;
				recv_idle_pct = 71;
			end
			send_random_point();
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
